[hdl/mlfq_pkg.sv]
// shared types, constants and helpers for the multilevel feedback scheduler
// no dependencies; used by every module of the block
`default_nettype none

package mlfq_pkg;

   localparam int MAX_PROCS  = 64;
   localparam int LEVELS     = 16;
   localparam int PID_W      = 6;
   localparam int LVL_W      = 4;
   localparam int CPU_W      = 10;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   typedef logic [PID_W-1:0]  pid_type;
   typedef logic [LVL_W-1:0]  lvl_type;
   typedef logic [CPU_W-1:0]  cpu_type;
   typedef logic [LEVELS-1:0] lvl_mask_type;

   localparam cpu_type SLICE_RESET = 10'd100;
   localparam lvl_type START_RESET = 4'd8;
   localparam lvl_type TOP_LEVEL   = LVL_W'(LEVELS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_READY    = 2'd0,
      KIND_DISPATCH = 2'd1,
      KIND_WAIT     = 2'd2,
      KIND_TERM     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_UNKNOWN = 2'd0,
      PH_READY   = 2'd1,
      PH_RUNNING = 2'd2,
      PH_WAITING = 2'd3
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLICE = 1'b0,
      CSR_START = 1'b1
   } csr_type;

   typedef struct packed {
      lvl_type   lvl;
      phase_type phase;
   } proc_entry_type;

   // level and phase share one address, each has its own enable
   typedef struct packed {
      logic      lvl_en;
      logic      phase_en;
      pid_type   addr;
      lvl_type   lvl;
      phase_type phase;
   } proc_wr_type;

   typedef struct packed {
      logic    en;
      pid_type addr;
      pid_type data;
   } link_wr_type;

   // highest set bit, 0 when none
   function automatic lvl_type top_level(input lvl_mask_type bits);
      lvl_type res;
      res = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (bits[i]) begin
            res = LVL_W'(i);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/multilevel_feedback_scheduler_core.sv]
// Multilevel feedback queue process scheduler, 16 levels, 64 process ids.
// Input channel req_*: one event per beat (kind, proc_id, cpu_used).
// Result channel rsp_*: exactly one result beat per event, in event order
// (chosen_id, dispatched, level).
// Config channel csr_*: index 0 slice_length, index 1 start_level; csr_ready
// is always high, writes are meant for idle periods.
// An accepted event waits in the event register; when it moves on, its result
// is loaded into the result register, and the beat is valid from there.
// Throughput: one event per cycle while the result register is not stalled.
// The process table is read at the edge that accepts the event, so the event
// logic runs in the cycle the item leaves the event register, updates the
// queues and loads the result register.
// A stall on rsp_stall holds the result register; the event register keeps
// filling, and req_stall rises once both stages are full.
// Reset (synchronous): all levels empty, every process unknown at level 0,
// slice_length 100, start_level 8. No clearing pass is needed; the block
// takes events as soon as reset is released.
`default_nettype none

module multilevel_feedback_scheduler_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [mlfq_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [mlfq_pkg::PID_W-1:0]        req_proc_id,
   input  wire logic [mlfq_pkg::CPU_W-1:0]        req_cpu_used,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [mlfq_pkg::PID_W-1:0]             rsp_chosen_id,
   output logic                                   rsp_dispatched,
   output logic [mlfq_pkg::LVL_W-1:0]             rsp_level,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mlfq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mlfq_pkg::CSR_DATA_W-1:0]   csr_data
);

   mlfq_pkg::cpu_type slice_ff;
   mlfq_pkg::lvl_type start_ff;

   logic               s1_valid_ff;
   mlfq_pkg::kind_type s1_kind_ff;
   mlfq_pkg::pid_type  s1_pid_ff;
   mlfq_pkg::cpu_type  s1_cpu_ff;

   logic              rsp_valid_ff, rsp_disp_ff;
   mlfq_pkg::pid_type rsp_id_ff;
   mlfq_pkg::lvl_type rsp_lvl_ff;

   logic advance, go, load;

   mlfq_pkg::pid_type        tbl_rd_addr, link_rd_addr, link_head_next;
   mlfq_pkg::proc_entry_type entry;
   mlfq_pkg::proc_wr_type    proc_wr;
   mlfq_pkg::link_wr_type    link_wr;
   mlfq_pkg::pid_type        res_id;
   logic                     res_disp;
   mlfq_pkg::lvl_type        res_lvl;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign go        = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= mlfq_pkg::SLICE_RESET;
         start_ff <= mlfq_pkg::START_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (mlfq_pkg::csr_type'(csr_index))
            mlfq_pkg::CSR_SLICE: slice_ff <= csr_data;
            mlfq_pkg::CSR_START: start_ff <= csr_data[mlfq_pkg::LVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // event register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_kind_ff <= mlfq_pkg::kind_type'(req_kind);
         s1_pid_ff  <= req_proc_id;
         s1_cpu_ff  <= req_cpu_used;
      end
   end

   // table read follows whatever sits in the event register next cycle
   assign tbl_rd_addr = load ? req_proc_id : s1_pid_ff;

   mlfq_proc_table u_proc_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (tbl_rd_addr),
      .wr       (proc_wr),
      .rd_entry (entry)
   );

   mlfq_link_mem u_link_mem (
      .clock   (clock),
      .rd_addr (link_rd_addr),
      .wr      (link_wr),
      .rd_data (link_head_next)
   );

   mlfq_sched_step u_step (
      .clock          (clock),
      .reset          (reset),
      .go             (go),
      .kind           (s1_kind_ff),
      .pid            (s1_pid_ff),
      .cpu_used       (s1_cpu_ff),
      .entry          (entry),
      .link_head_next (link_head_next),
      .slice_length   (slice_ff),
      .start_level    (start_ff),
      .proc_wr        (proc_wr),
      .link_wr        (link_wr),
      .link_rd_addr   (link_rd_addr),
      .res_id         (res_id),
      .res_disp       (res_disp),
      .res_lvl        (res_lvl)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_id_ff   <= res_id;
         rsp_disp_ff <= res_disp;
         rsp_lvl_ff  <= res_lvl;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chosen_id  = rsp_id_ff;
   assign rsp_dispatched = rsp_disp_ff;
   assign rsp_level      = rsp_lvl_ff;

`ifndef ASSERT_OFF
   a_go_gives_result: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("handled event produced no result beat");

   a_dispatch_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_disp_ff) |-> (rsp_id_ff != '0))
      else $error("dispatch selected pid zero");

   a_pid_zero_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_id_ff == '0) |-> (rsp_lvl_ff == '0 && !rsp_disp_ff))
      else $error("result for no pid carries a level");

   a_event_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_pid_ff)))
      else $error("event register changed while blocked");
`endif

endmodule

`default_nettype wire

[hdl/mlfq_proc_table.sv]
// per-process level and phase table: memory with registered read and write bypass
// valid bits make never-written entries read as unknown at level 0; uses mlfq_pkg
`default_nettype none

module mlfq_proc_table (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mlfq_pkg::pid_type       rd_addr,
   input  wire mlfq_pkg::proc_wr_type   wr,
   output mlfq_pkg::proc_entry_type     rd_entry
);

   mlfq_pkg::lvl_type   lvl_mem   [mlfq_pkg::MAX_PROCS];
   mlfq_pkg::phase_type phase_mem [mlfq_pkg::MAX_PROCS];

   logic [mlfq_pkg::MAX_PROCS-1:0] valid_ff, valid_in;

   mlfq_pkg::lvl_type   lvl_rd_ff, lvl_byp_data_ff;
   mlfq_pkg::phase_type phase_rd_ff, phase_byp_data_ff;
   logic                lvl_byp_ff, phase_byp_ff, hit_ff;
   logic                any_wr, same_addr;

   assign any_wr    = wr.lvl_en || wr.phase_en;
   assign same_addr = (wr.addr == rd_addr);

   always_comb begin
      valid_in = valid_ff;
      if (any_wr) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.lvl_en) begin
         lvl_mem[wr.addr] <= wr.lvl;
      end
      if (wr.phase_en) begin
         phase_mem[wr.addr] <= wr.phase;
      end
      lvl_rd_ff   <= lvl_mem[rd_addr];
      phase_rd_ff <= phase_mem[rd_addr];
   end

   // a write landing on the address being read wins over the array
   always_ff @(posedge clock) begin
      lvl_byp_ff        <= wr.lvl_en && same_addr;
      phase_byp_ff      <= wr.phase_en && same_addr;
      lvl_byp_data_ff   <= wr.lvl;
      phase_byp_data_ff <= wr.phase;
      hit_ff            <= valid_ff[rd_addr] || (any_wr && same_addr);
   end

   always_comb begin
      rd_entry.lvl   = lvl_byp_ff ? lvl_byp_data_ff :
                       (hit_ff ? lvl_rd_ff : '0);
      rd_entry.phase = phase_byp_ff ? phase_byp_data_ff :
                       (hit_ff ? phase_rd_ff : mlfq_pkg::PH_UNKNOWN);
   end

endmodule

`default_nettype wire

[hdl/mlfq_link_mem.sv]
// queue link memory: one write port, one registered read port with write bypass
// an entry's read data is only used after the entry is written; uses mlfq_pkg
`default_nettype none

module mlfq_link_mem (
   input  wire logic                  clock,
   input  wire mlfq_pkg::pid_type     rd_addr,
   input  wire mlfq_pkg::link_wr_type wr,
   output mlfq_pkg::pid_type          rd_data
);

   mlfq_pkg::pid_type link_mem [mlfq_pkg::MAX_PROCS];

   mlfq_pkg::pid_type rd_ff, byp_data_ff;
   logic              byp_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr] <= wr.data;
      end
      rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      byp_ff      <= wr.en && (wr.addr == rd_addr);
      byp_data_ff <= wr.data;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

`default_nettype wire

[hdl/mlfq_sched_step.sv]
// event logic and queue end registers: one event handled per cycle while go is high
// drives table and link writes and the link prefetch address; uses mlfq_pkg
`default_nettype none

module mlfq_sched_step (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go,
   input  wire mlfq_pkg::kind_type       kind,
   input  wire mlfq_pkg::pid_type        pid,
   input  wire mlfq_pkg::cpu_type        cpu_used,
   input  wire mlfq_pkg::proc_entry_type entry,
   input  wire mlfq_pkg::pid_type        link_head_next,
   input  wire mlfq_pkg::cpu_type        slice_length,
   input  wire mlfq_pkg::lvl_type        start_level,
   output mlfq_pkg::proc_wr_type         proc_wr,
   output mlfq_pkg::link_wr_type         link_wr,
   output mlfq_pkg::pid_type             link_rd_addr,
   output mlfq_pkg::pid_type             res_id,
   output logic                          res_disp,
   output mlfq_pkg::lvl_type             res_lvl
);

   mlfq_pkg::pid_type      head_ff [mlfq_pkg::LEVELS];
   mlfq_pkg::pid_type      head_in [mlfq_pkg::LEVELS];
   mlfq_pkg::pid_type      tail_ff [mlfq_pkg::LEVELS];
   mlfq_pkg::pid_type      tail_in [mlfq_pkg::LEVELS];
   mlfq_pkg::lvl_mask_type nonempty_ff, nonempty_in;

   mlfq_pkg::lvl_type top_lvl, new_lvl, down_lvl, start_sat;
   mlfq_pkg::pid_type disp_pid;
   logic              enq;

   assign top_lvl   = mlfq_pkg::top_level(nonempty_ff);
   assign disp_pid  = head_ff[top_lvl];
   assign start_sat = (start_level > mlfq_pkg::TOP_LEVEL) ? mlfq_pkg::TOP_LEVEL : start_level;
   assign down_lvl  = (cpu_used == slice_length && entry.lvl != '0) ?
                      entry.lvl - mlfq_pkg::lvl_type'(1) : entry.lvl;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      proc_wr     = '0;
      link_wr     = '0;
      res_id      = pid;
      res_disp    = 1'b0;
      res_lvl     = '0;
      new_lvl     = entry.lvl;
      enq         = 1'b0;

      if (go) begin
         if (kind == mlfq_pkg::KIND_DISPATCH) begin
            res_id = '0;
            if (|nonempty_ff) begin
               if (head_ff[top_lvl] == tail_ff[top_lvl]) begin
                  nonempty_in[top_lvl] = 1'b0;
               end else begin
                  head_in[top_lvl] = link_head_next;
               end
               proc_wr.phase_en = 1'b1;
               proc_wr.addr     = disp_pid;
               proc_wr.phase    = mlfq_pkg::PH_RUNNING;
               res_id           = disp_pid;
               res_disp         = 1'b1;
               res_lvl          = top_lvl;
            end
         end else if (pid != '0) begin
            // every 6-bit pid is inside the table, so only pid zero is rejected
            proc_wr.addr = pid;
            unique case (kind)
               mlfq_pkg::KIND_READY: begin
                  if (entry.phase == mlfq_pkg::PH_UNKNOWN) begin
                     new_lvl = start_sat;
                     enq     = 1'b1;
                  end else if (entry.phase == mlfq_pkg::PH_RUNNING ||
                               entry.phase == mlfq_pkg::PH_WAITING) begin
                     // demote on a full slice, then promote after a wait
                     if (entry.phase == mlfq_pkg::PH_WAITING &&
                         down_lvl < mlfq_pkg::TOP_LEVEL) begin
                        new_lvl = down_lvl + mlfq_pkg::lvl_type'(1);
                     end else begin
                        new_lvl = down_lvl;
                     end
                     enq = 1'b1;
                  end
                  if (enq) begin
                     proc_wr.lvl_en   = 1'b1;
                     proc_wr.phase_en = 1'b1;
                     proc_wr.lvl      = new_lvl;
                     proc_wr.phase    = mlfq_pkg::PH_READY;
                  end
               end
               mlfq_pkg::KIND_WAIT: begin
                  if (entry.phase == mlfq_pkg::PH_RUNNING) begin
                     proc_wr.phase_en = 1'b1;
                     proc_wr.phase    = mlfq_pkg::PH_WAITING;
                  end
               end
               mlfq_pkg::KIND_TERM: begin
                  if (entry.phase == mlfq_pkg::PH_RUNNING ||
                      entry.phase == mlfq_pkg::PH_WAITING) begin
                     proc_wr.lvl_en   = 1'b1;
                     proc_wr.phase_en = 1'b1;
                     proc_wr.lvl      = '0;
                     proc_wr.phase    = mlfq_pkg::PH_UNKNOWN;
                     new_lvl          = '0;
                  end
               end
               default: begin
               end
            endcase
            res_lvl = new_lvl;

            if (enq) begin
               if (nonempty_ff[new_lvl]) begin
                  link_wr.en   = 1'b1;
                  link_wr.addr = tail_ff[new_lvl];
                  link_wr.data = pid;
               end else begin
                  head_in[new_lvl]     = pid;
                  nonempty_in[new_lvl] = 1'b1;
               end
               tail_in[new_lvl] = pid;
            end
         end
      end
   end

   // prefetch the successor of the head that the next dispatch would pop
   assign link_rd_addr = head_in[mlfq_pkg::top_level(nonempty_in)];

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         nonempty_ff <= nonempty_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
   end

endmodule

`default_nettype wire

[tb/sv/mlfq_sched_checker.sv]
// result checker for the multilevel feedback scheduler core
// tracks queues and process table from accepted events and compares every result beat
// depends on mlfq_pkg
`timescale 1ns / 100ps

module mlfq_sched_checker
   import mlfq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [PID_W-1:0]      req_proc_id,
   input  wire logic [CPU_W-1:0]      req_cpu_used,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [PID_W-1:0]      rsp_chosen_id,
   input  wire logic                  rsp_dispatched,
   input  wire logic [LVL_W-1:0]      rsp_level,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      pid_type id;
      logic    disp;
      lvl_type lvl;
   } sched_result_type;

   cpu_type          slice_len;
   lvl_type          start_lvl;
   pid_type          q_head [LEVELS];
   pid_type          q_tail [LEVELS];
   lvl_mask_type     q_busy;
   pid_type          q_next [MAX_PROCS];
   lvl_type          proc_lvl [MAX_PROCS];
   phase_type        proc_ph [MAX_PROCS];
   sched_result_type sched_expected[$];
   int               fails = 0;
   int               outstanding = 0;
   int               n_results = 0;

   assign fail_count = fails;
   assign pending    = outstanding;

   task automatic report(input string msg);
      $display("%0t ns: result %0d: %s", $realtime, n_results, msg);
      fails++;
   endtask

   function automatic void append_to_level(input pid_type pid, input lvl_type lv);
      if (q_busy[lv]) begin
         q_next[q_tail[lv]] = pid;
      end else begin
         q_head[lv] = pid;
         q_busy[lv] = 1'b1;
      end
      q_tail[lv] = pid;
   endfunction

   function automatic sched_result_type schedule_event(input kind_type kind,
                                                       input pid_type pid,
                                                       input cpu_type cpu);
      sched_result_type r;
      phase_type        ph;
      lvl_type          lv;
      pid_type          p;
      r.id   = pid;
      r.disp = 1'b0;
      r.lvl  = '0;
      if (kind == KIND_DISPATCH) begin
         r.id = '0;
         for (int i = LEVELS - 1; i >= 0; i--) begin
            if (q_busy[i] && !r.disp) begin
               p = q_head[i];
               if (q_head[i] == q_tail[i]) begin
                  q_busy[i] = 1'b0;
               end else begin
                  q_head[i] = q_next[p];
               end
               proc_ph[p] = PH_RUNNING;
               r.id   = p;
               r.disp = 1'b1;
               r.lvl  = LVL_W'(i);
            end
         end
      end else if (pid != '0) begin
         ph = proc_ph[pid];
         lv = proc_lvl[pid];
         case (kind)
            KIND_READY: begin
               // a 4-bit start level can never exceed the top level
               if (ph == PH_UNKNOWN) begin
                  proc_lvl[pid] = start_lvl;
                  proc_ph[pid]  = PH_READY;
                  append_to_level(pid, start_lvl);
               end else if (ph == PH_RUNNING || ph == PH_WAITING) begin
                  // demote first, then promote
                  if (cpu == slice_len && lv != '0) lv = lv - 1'b1;
                  if (ph == PH_WAITING && lv != TOP_LEVEL) lv = lv + 1'b1;
                  proc_lvl[pid] = lv;
                  proc_ph[pid]  = PH_READY;
                  append_to_level(pid, lv);
               end
            end
            KIND_WAIT: begin
               if (ph == PH_RUNNING) proc_ph[pid] = PH_WAITING;
            end
            default: begin
               if (ph == PH_RUNNING || ph == PH_WAITING) begin
                  proc_ph[pid]  = PH_UNKNOWN;
                  proc_lvl[pid] = '0;
               end
            end
         endcase
         r.lvl = proc_lvl[pid];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         slice_len = SLICE_RESET;
         start_lvl = START_RESET;
         q_busy    = '0;
         foreach (q_head[i]) begin
            q_head[i] = '0;
            q_tail[i] = '0;
         end
         foreach (proc_lvl[i]) begin
            q_next[i]   = '0;
            proc_lvl[i] = '0;
            proc_ph[i]  = PH_UNKNOWN;
         end
         sched_expected.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sched_expected.size() == 0) begin
               report($sformatf("result beat id=%0d disp=%0d level=%0d with none pending",
                                rsp_chosen_id, rsp_dispatched, rsp_level));
            end else begin
               want = sched_expected.pop_front();
               if (rsp_chosen_id !== want.id)
                  report($sformatf("chosen_id %0d, expected %0d", rsp_chosen_id, want.id));
               if (rsp_dispatched !== want.disp)
                  report($sformatf("dispatched %0d, expected %0d", rsp_dispatched, want.disp));
               if (rsp_level !== want.lvl)
                  report($sformatf("level %0d, expected %0d", rsp_level, want.lvl));
            end
            n_results++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_SLICE: slice_len = csr_data[CPU_W-1:0];
               CSR_START: start_lvl = csr_data[LVL_W-1:0];
            endcase
         end
         if (req_valid && !req_stall) begin
            sched_expected.push_back(schedule_event(kind_type'(req_kind), req_proc_id,
                                                    req_cpu_used));
         end
      end
      outstanding = sched_expected.size();
   end

endmodule

[tb/sv/multilevel_feedback_scheduler_core_tb.sv]
// top of the multilevel feedback scheduler testbench: clock, reset, event traffic
// and register writes; checking lives in mlfq_sched_checker
// depends on mlfq_pkg, multilevel_feedback_scheduler_core and mlfq_sched_checker
`timescale 1ns / 100ps

module multilevel_feedback_scheduler_core_tb;
   import mlfq_pkg::*;

   localparam realtime HALF_PERIOD = 6;
   localparam int      PHASES      = 6;
   localparam int      PHASE_ITEMS = 280;
   localparam int      POOL        = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [PID_W-1:0]      req_proc_id = '0;
   logic [CPU_W-1:0]      req_cpu_used = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PID_W-1:0]      rsp_chosen_id;
   logic                  rsp_dispatched;
   logic [LVL_W-1:0]      rsp_level;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    pending;
   logic                  want_hold = 1'b0;
   cpu_type               cur_slice = SLICE_RESET;

   multilevel_feedback_scheduler_core u_top (.*);

   mlfq_sched_checker u_check (.*);

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver pacing: free-running, light and heavy stall segments, long hold-offs
   initial begin
      int  seg;
      int  mode;
      int  holds;
      logic s;
      holds = 0;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 19);
         if ((want_hold && holds == 0) || mode == 19) begin
            // only hold-offs under live traffic count toward the forced one
            if (want_hold) holds++;
            rsp_stall <= 1'b1;
            repeat ($urandom_range(60, 120)) @(negedge clock);
         end else begin
            seg = $urandom_range(8, 60);
            for (int c = 0; c < seg; c++) begin
               if (mode < 7) s = 1'b0;
               else if (mode < 13) s = ($urandom_range(0, 99) < 30);
               else s = ($urandom_range(0, 99) < 75);
               rsp_stall <= s;
               @(negedge clock);
            end
         end
      end
   end

   // valid stays up after the beat; the caller drops it for a gap
   task automatic send_event(input kind_type k, input pid_type p, input cpu_type c);
      req_valid    <= 1'b1;
      req_kind     <= k;
      req_proc_id  <= p;
      req_cpu_used <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] slice,
                             input logic [CSR_DATA_W-1:0] start);
      drain();
      write_csr(CSR_SLICE, slice);
      write_csr(CSR_START, start);
      csr_valid <= 1'b0;
      cur_slice = slice;
      @(negedge clock);
   endtask

   function automatic cpu_type pick_cpu;
      case ($urandom_range(0, 3))
         0: return cur_slice;
         1: return '0;
         2: return CPU_W'($urandom_range(0, 1023));
         default: return (cur_slice == 10'd1023) ? cur_slice - 1'b1 : cur_slice + 1'b1;
      endcase
   endfunction

   task automatic run_traffic(input int n);
      pid_type  pool [POOL];
      kind_type k;
      pid_type  p;
      int       r;
      int       burst;
      int       sent;
      foreach (pool[i]) pool[i] = PID_W'($urandom_range(1, 63));
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < n; b++) begin
            r = $urandom_range(0, 99);
            p = pool[$urandom_range(0, POOL - 1)];
            if (r < 30) begin
               k = KIND_DISPATCH;
               p = PID_W'($urandom_range(0, 63));
            end else if (r < 62) begin
               k = KIND_READY;
            end else if (r < 80) begin
               k = KIND_WAIT;
            end else if (r < 90) begin
               k = KIND_TERM;
            end else begin
               // noise: any kind, any pid, pid zero often
               k = kind_type'($urandom_range(0, 3));
               p = ($urandom_range(0, 3) == 0) ? '0 : PID_W'($urandom_range(1, 63));
            end
            send_event(k, p, pick_cpu());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset configuration (slice 100, start level 8)
      send_event(KIND_DISPATCH, 6'd0,  10'd0);      // idle dispatch
      send_event(KIND_READY,    6'd0,  10'd1023);   // pid zero
      send_event(KIND_READY,    6'd63, 10'd0);      // new at start level
      send_event(KIND_READY,    6'd63, 10'd0);      // already queued
      send_event(KIND_READY,    6'd1,  10'd0);
      send_event(KIND_WAIT,     6'd1,  10'd0);      // wait while not running
      send_event(KIND_TERM,     6'd1,  10'd0);      // terminate while queued
      send_event(KIND_DISPATCH, 6'd63, 10'd0);
      send_event(KIND_READY,    6'd63, SLICE_RESET); // full slice demotes
      send_event(KIND_DISPATCH, 6'd0,  10'd0);
      send_event(KIND_WAIT,     6'd1,  10'd0);
      send_event(KIND_READY,    6'd1,  SLICE_RESET); // demote and promote together
      send_event(KIND_DISPATCH, 6'd42, 10'd0);
      send_event(KIND_TERM,     6'd1,  10'd0);      // terminate while running
      send_event(KIND_DISPATCH, 6'd21, 10'd0);
      send_event(KIND_WAIT,     6'd63, 10'd0);
      send_event(KIND_TERM,     6'd63, 10'd0);      // terminate while waiting
      send_event(KIND_DISPATCH, 6'd63, 10'd1023);   // idle again
      send_event(KIND_READY,    6'd42, 10'd1023);
      send_event(KIND_DISPATCH, 6'd0,  10'd0);
      send_event(KIND_WAIT,     6'd42, 10'd0);
      send_event(KIND_READY,    6'd42, 10'd0);      // promotion after waiting
      send_event(KIND_TERM,     6'd0,  10'd0);
      send_event(KIND_WAIT,     6'd0,  10'd0);
      send_event(KIND_TERM,     6'd42, 10'd0);      // queued, left alone

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_config(10'd1023, 10'd15);
            1: set_config(10'd1, 10'd0);
            2: set_config(CSR_DATA_W'($urandom_range(1, 1023)),
                          {6'($urandom_range(0, 63)), 4'($urandom_range(0, 15))});
            3: set_config(SLICE_RESET, CSR_DATA_W'(START_RESET));
            4: set_config(CSR_DATA_W'($urandom_range(1, 1023)),
                          CSR_DATA_W'($urandom_range(0, 15)));
            default: set_config(10'd1023, 10'd0);
         endcase
         if (ph == 1) want_hold <= 1'b1;
         run_traffic(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
